// ===== rtl/pdse_pkg.sv =====
// Shared types and constants for the prefix delta string encoder.
package pdse_pkg;

    localparam int MAX_KEY_BYTES_DEF = 256;

    localparam int POS_W  = 9;   // byte position within a key
    localparam int LEN_W  = 9;   // key length field
    localparam int PLEN_W = 10;  // stored previous length, holds 512
    localparam int VAL_W  = 10;  // header varint values
    localparam int RI_W   = 11;
    localparam int KSR_W  = 11;
    localparam int OFS_W  = 24;
    localparam int IDX_W  = 16;
    localparam int BUNDLE_BYTES = 5;
    localparam int CNT_W  = 3;

    localparam logic [RI_W-1:0]  RESTART_INTERVAL_RST = 11'd16;
    localparam logic [KSR_W-1:0] KSR_MAX = '1;
    localparam logic [OFS_W-1:0] OFS_MAX = '1;
    localparam logic [IDX_W-1:0] IDX_MAX = '1;

    // action codes carried in s_tuser
    localparam logic ACT_KEY_BYTE    = 1'b0;
    localparam logic ACT_BLOCK_START = 1'b1;

    typedef struct packed {
        logic             action;
        logic [7:0]       key_byte;
        logic [LEN_W-1:0] key_length;
        logic [POS_W-1:0] pos;
        logic             ends;
        logic             in_store;
    } pdse_item_t;

    typedef struct packed {
        logic [BUNDLE_BYTES-1:0][7:0] data;
        logic [CNT_W-1:0]             count;
        logic                         mark;
        logic                         last;
        logic [OFS_W-1:0]             offset;
        logic [IDX_W-1:0]             index;
    } pdse_bundle_t;

endpackage

// ===== rtl/pdse_key_store.sv =====
// Previous-key byte store: one write port, one registered read port with forwarding.
module pdse_key_store #(
    parameter int MAX_KEY_BYTES = pdse_pkg::MAX_KEY_BYTES_DEF,
    localparam int AW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1
) (
    input  logic          aclk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data
);
    logic [7:0] mem [MAX_KEY_BYTES];
    logic [7:0] q_reg;
    logic       fwd_reg;
    logic [7:0] fwd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            q_reg        <= mem[rd_addr];
            // same-cycle write to the read entry wins
            fwd_reg      <= wr_en && (wr_addr == rd_addr);
            fwd_data_reg <= wr_data;
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : q_reg;

endmodule

// ===== rtl/pdse_entry_unit.sv =====
// Compare stage: matches a key byte against the store, updates entry state, builds output words.
module pdse_entry_unit #(
    parameter int MAX_KEY_BYTES = pdse_pkg::MAX_KEY_BYTES_DEF,
    localparam int AW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [10:0]           cfg_wr_data,
    input  logic                  item_valid,
    input  pdse_pkg::pdse_item_t  item,
    output logic                  item_ready,
    input  logic [7:0]            rd_data,
    output logic                  wr_en,
    output logic [AW-1:0]         wr_addr,
    output logic [7:0]            wr_data,
    output logic                  push,
    output pdse_pkg::pdse_bundle_t bundle,
    input  logic                  push_ready
);
    import pdse_pkg::*;

    logic              s1_valid_reg;
    pdse_item_t        s1_reg;
    logic [RI_W-1:0]   ri_reg;
    logic [PLEN_W-1:0] prev_len_reg, prev_len_next;
    logic [VAL_W-1:0]  shared_reg, shared_next;
    logic              matching_reg, matching_next;
    logic [KSR_W-1:0]  ksr_reg, ksr_next;
    logic [OFS_W-1:0]  opos_reg, opos_next;
    logic [IDX_W-1:0]  kcount_reg, kcount_next;

    logic              first, empty, match, sm, advance;
    logic              emit_hdr, emit_byte;
    logic [KSR_W-1:0]  ksr_eff;
    logic [VAL_W-1:0]  sh, pos1, len10, total, hdr_shared, hdr_unshared;
    logic [CNT_W-1:0]  k;
    logic [OFS_W:0]    opos_sum;
    logic [AW+POS_W-1:0] pos_ext;

    assign first = (s1_reg.pos == '0);
    assign empty = (s1_reg.key_length == '0) && first;
    assign ksr_eff = (first && (ksr_reg >= ri_reg)) ? '0 : ksr_reg;
    assign sh = first ? '0 : shared_reg;
    assign sm = first || matching_reg;
    assign pos1 = {1'b0, s1_reg.pos} + 10'd1;
    assign len10 = {1'b0, s1_reg.key_length};
    assign total = (len10 > pos1) ? len10 : pos1;
    assign match = (ksr_eff != '0) && ({1'b0, s1_reg.pos} < prev_len_reg)
                   && s1_reg.in_store && (rd_data == s1_reg.key_byte);

    always_comb begin
        emit_hdr     = 1'b0;
        emit_byte    = 1'b0;
        hdr_shared   = '0;
        hdr_unshared = '0;
        shared_next  = sh;
        matching_next = sm;
        if (empty) begin
            emit_hdr = 1'b1;
        end else if (sm && match) begin
            shared_next = sh + 10'd1;
            emit_hdr    = s1_reg.ends;
            hdr_shared  = sh + 10'd1;
        end else if (sm) begin
            emit_hdr      = 1'b1;
            emit_byte     = 1'b1;
            hdr_shared    = sh;
            hdr_unshared  = total - sh;
            matching_next = 1'b0;
        end else begin
            emit_byte = 1'b1;
        end
    end

    // header varints, low 7-bit group first, then the pass-through byte
    always_comb begin
        bundle.data = '0;
        k = '0;
        if (emit_hdr) begin
            if (hdr_shared >= 10'd128) begin
                bundle.data[k] = {1'b1, hdr_shared[6:0]};
                k = k + 3'd1;
                bundle.data[k] = 8'(hdr_shared[9:7]);
            end else begin
                bundle.data[k] = hdr_shared[7:0];
            end
            k = k + 3'd1;
            if (hdr_unshared >= 10'd128) begin
                bundle.data[k] = {1'b1, hdr_unshared[6:0]};
                k = k + 3'd1;
                bundle.data[k] = 8'(hdr_unshared[9:7]);
            end else begin
                bundle.data[k] = hdr_unshared[7:0];
            end
            k = k + 3'd1;
        end
        if (emit_byte) begin
            bundle.data[k] = s1_reg.key_byte;
            k = k + 3'd1;
        end
        if (s1_reg.action == ACT_BLOCK_START) begin
            k = '0;
        end
        bundle.count  = k;
        bundle.mark   = emit_hdr && (ksr_eff == '0);
        bundle.last   = s1_reg.ends;
        bundle.offset = opos_reg;
        bundle.index  = kcount_reg;
    end

    assign advance    = s1_valid_reg && ((bundle.count == '0) || push_ready);
    assign item_ready = !s1_valid_reg || advance;
    assign push       = advance && (bundle.count != '0);

    assign pos_ext = {{AW{1'b0}}, s1_reg.pos};
    assign wr_en   = advance && (s1_reg.action == ACT_KEY_BYTE) && !empty && s1_reg.in_store;
    assign wr_addr = pos_ext[AW-1:0];
    assign wr_data = s1_reg.key_byte;

    assign opos_sum = {1'b0, opos_reg} + 25'(bundle.count);
    assign opos_next = (opos_sum > {1'b0, OFS_MAX}) ? OFS_MAX : opos_sum[OFS_W-1:0];

    always_comb begin
        prev_len_next = prev_len_reg;
        ksr_next      = ksr_eff;
        kcount_next   = kcount_reg;
        if (s1_reg.ends) begin
            if (empty) begin
                prev_len_next = '0;
            end else if (int'(pos1) > MAX_KEY_BYTES) begin
                prev_len_next = PLEN_W'(MAX_KEY_BYTES);
            end else begin
                prev_len_next = pos1;
            end
            if (ksr_eff != KSR_MAX) begin
                ksr_next = ksr_eff + 11'd1;
            end
            if (kcount_reg != IDX_MAX) begin
                kcount_next = kcount_reg + 16'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            ri_reg       <= RESTART_INTERVAL_RST;
            prev_len_reg <= '0;
            shared_reg   <= '0;
            matching_reg <= 1'b1;
            ksr_reg      <= '0;
            opos_reg     <= '0;
            kcount_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                ri_reg <= cfg_wr_data;
            end
            if (item_ready) begin
                s1_valid_reg <= item_valid;
            end
            if (advance) begin
                if (s1_reg.action == ACT_BLOCK_START) begin
                    prev_len_reg <= '0;
                    shared_reg   <= '0;
                    matching_reg <= 1'b1;
                    ksr_reg      <= '0;
                    opos_reg     <= '0;
                    kcount_reg   <= '0;
                end else begin
                    prev_len_reg <= prev_len_next;
                    shared_reg   <= shared_next;
                    matching_reg <= s1_reg.ends ? 1'b1 : matching_next;
                    ksr_reg      <= ksr_next;
                    opos_reg     <= opos_next;
                    kcount_reg   <= kcount_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (item_ready && item_valid) begin
            s1_reg <= item;
        end
    end

endmodule

// ===== rtl/pdse_out_serializer.sv =====
// Output register: sends the bytes of one entry word group one word per cycle while out_ready is high.
module pdse_out_serializer (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  pdse_pkg::pdse_bundle_t bundle,
    output logic                   push_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             out_byte,
    output logic [23:0]            out_offset,
    output logic                   restart_mark,
    output logic [15:0]            entry_index,
    output logic                   entry_last
);
    import pdse_pkg::*;

    logic             valid_reg;
    pdse_bundle_t     b_reg;
    logic [CNT_W-1:0] sel_reg;
    logic [OFS_W-1:0] off_reg;
    logic             at_last;

    assign at_last    = (sel_reg == (b_reg.count - 3'd1));
    assign push_ready = !valid_reg || (out_ready && at_last);

    assign out_valid    = valid_reg;
    assign out_byte     = b_reg.data[sel_reg];
    assign out_offset   = off_reg;
    assign restart_mark = b_reg.mark && (sel_reg == '0);
    assign entry_index  = b_reg.index;
    assign entry_last   = b_reg.last && at_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            sel_reg   <= '0;
        end else if (push_ready) begin
            valid_reg <= push;
            sel_reg   <= '0;
        end else if (out_ready) begin
            sel_reg <= sel_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push && push_ready) begin
            b_reg   <= bundle;
            off_reg <= bundle.offset;
        end else if (valid_reg && out_ready && (off_reg != OFS_MAX)) begin
            off_reg <= off_reg + 24'd1;
        end
    end

endmodule

// ===== rtl/prefix_delta_string_encoder.sv =====
// Top level of the prefix delta string encoder (front coding of sorted keys).
//
//  channel  | direction | contents
//  ---------+-----------+---------------------------------------------------
//  s_*      | in        | one key byte per word, key length, action in tuser
//  m_*      | out       | one encoded byte per word with offset and entry index
//  cfg_wr_* | in        | restart_interval write
//
// A key byte is accepted every cycle while the output keeps up. A byte that
// ends the shared prefix emits up to five words (two varints plus the byte),
// one per cycle on m_* while m_tready is high, and the next byte that emits
// words waits in the compare stage until the last of them is taken. From s_*
// to m_* a word passes the previous-key memory read register and the output
// register. Reset is synchronous and needs no clearing pass.
module prefix_delta_string_encoder #(
    parameter int MAX_KEY_BYTES = pdse_pkg::MAX_KEY_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [10:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] key_byte, [16:8] key_length, [23:17] zero
    input  logic        s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [7:0] out_byte, [31:8] out_offset, [47:32] entry_index
    output logic        m_tuser,   // restart_mark
    output logic        m_tlast    // entry_last
);
    import pdse_pkg::*;

    localparam int AW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

    logic [POS_W-1:0]    bp_reg;
    logic                accept;
    pdse_item_t          item;
    logic [AW+POS_W-1:0] pos_ext;
    logic [7:0]          rd_data;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [7:0]          wr_data;
    logic                push, push_ready;
    pdse_bundle_t        bundle;
    logic [7:0]          out_byte;
    logic [23:0]         out_offset;
    logic [15:0]         entry_index;

    assign accept = s_tvalid && s_tready;

    assign item.action     = s_tuser;
    assign item.key_byte   = s_tdata[7:0];
    assign item.key_length = s_tdata[16:8];
    assign item.pos        = bp_reg;
    // zero length also lands here: the empty key ends on its only word
    assign item.ends       = ({1'b0, bp_reg} + 10'd1) >= {1'b0, s_tdata[16:8]};
    assign item.in_store   = int'(bp_reg) < MAX_KEY_BYTES;

    assign pos_ext = {{AW{1'b0}}, bp_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bp_reg <= '0;
        end else if (accept) begin
            if (s_tuser == ACT_BLOCK_START || item.ends) begin
                bp_reg <= '0;
            end else begin
                bp_reg <= bp_reg + 9'd1;
            end
        end
    end

    pdse_key_store #(
        .MAX_KEY_BYTES(MAX_KEY_BYTES)
    ) u_store (
        .aclk    (aclk),
        .rd_en   (accept && item.in_store),
        .rd_addr (pos_ext[AW-1:0]),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    pdse_entry_unit #(
        .MAX_KEY_BYTES(MAX_KEY_BYTES)
    ) u_entry (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_valid  (s_tvalid),
        .item        (item),
        .item_ready  (s_tready),
        .rd_data     (rd_data),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .push        (push),
        .bundle      (bundle),
        .push_ready  (push_ready)
    );

    pdse_out_serializer u_out (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push         (push),
        .bundle       (bundle),
        .push_ready   (push_ready),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_byte     (out_byte),
        .out_offset   (out_offset),
        .restart_mark (m_tuser),
        .entry_index  (entry_index),
        .entry_last   (m_tlast)
    );

    assign m_tdata = {entry_index, out_offset, out_byte};

endmodule
